// File: src/dart_pkg.sv
// ----------------------------------------------------------------------------
// dart_pkg
// Shared types, codes and constants for the divider and reload timer.
// ----------------------------------------------------------------------------
`default_nettype none

package dart_pkg;

   // Operation codes carried by a request transaction.
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   // Register select codes.
   typedef enum logic [1:0] {
      SEL_DIVIDER = 2'd0,
      SEL_COUNT   = 2'd1,
      SEL_MODULO  = 2'd2,
      SEL_CONTROL = 2'd3
   } sel_type;

   // Rate select codes from control bits 1:0.
   typedef enum logic [1:0] {
      RATE_SLOW   = 2'd0,
      RATE_FAST   = 2'd1,
      RATE_MEDIUM = 2'd2,
      RATE_LOW    = 2'd3
   } rate_type;

   localparam int unsigned ENABLE_BIT  = 2;
   localparam logic [15:0] MATCH_VALUE = 16'h0004;

   // One response transaction.
   typedef struct packed {
      logic [7:0] read_data;
      logic       timer_interrupt;
   } result_type;

   // Mask applied to the tick counter for each rate select.
   function automatic logic [15:0] rate_mask(input logic [1:0] rate);
      logic [15:0] mask;
      unique case (rate)
         RATE_SLOW:   mask = 16'h03FF;
         RATE_FAST:   mask = 16'h000F;
         RATE_MEDIUM: mask = 16'h001F;
         RATE_LOW:    mask = 16'h00FF;
         default:     mask = 16'h03FF;
      endcase
      return mask;
   endfunction

endpackage

`default_nettype wire

// File: src/dart_if.sv
// ----------------------------------------------------------------------------
// dart_req_if / dart_rsp_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface dart_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [1:0] reg_select;
   logic [7:0] write_data;

   modport source (output valid, output operation, output reg_select,
                   output write_data, input ready);
   modport sink (input valid, input operation, input reg_select,
                 input write_data, output ready);
endinterface

interface dart_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       timer_interrupt;

   modport source (output valid, output read_data, output timer_interrupt,
                   input ready);
   modport sink (input valid, input read_data, input timer_interrupt,
                 output ready);
endinterface

`default_nettype wire

// File: src/divider_and_reload_timer_core.sv
// ----------------------------------------------------------------------------
// divider_and_reload_timer_core
// Timer peripheral with a free-running divider and a reloading timer counter.
// Each request transaction is a tick, a register read or a register write,
// and yields exactly one response transaction carrying the read byte and a
// one-shot timer interrupt flag. While no response is stalled, one request is
// accepted every clock cycle; its response appears in the output register on
// the following cycle. The whole update is one increment, mask and compare
// between the state registers and the response register. A new request enters
// in the same cycle that the previous response is taken; while a response
// waits to be taken, the request side is held off.
// ----------------------------------------------------------------------------
`default_nettype none

module divider_and_reload_timer_core
   import dart_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   dart_req_if.sink   req_channel,
   dart_rsp_if.source rsp_channel
);

   logic       accept;
   logic       take_ready;
   result_type result;

   // Handshake on the request side.
   assign req_channel.ready = take_ready;
   assign accept            = req_channel.valid && take_ready;

   dart_timer u_timer (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (req_channel.operation),
      .reg_select (req_channel.reg_select),
      .write_data (req_channel.write_data),
      .result     (result)
   );

   dart_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .result      (result),
      .take_ready  (take_ready),
      .rsp_channel (rsp_channel)
   );

endmodule

`default_nettype wire

// File: src/dart_timer.sv
// ----------------------------------------------------------------------------
// dart_timer
// Architectural registers and the single-pass update for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dart_timer
   import dart_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [1:0] operation,
   input  wire logic [1:0] reg_select,
   input  wire logic [7:0] write_data,
   output result_type      result
);

   logic [15:0] tick_counter_ff, tick_counter_in;
   logic [7:0]  timer_count_ff, timer_count_in;
   logic [7:0]  reload_value_ff, reload_value_in;
   logic [7:0]  control_byte_ff, control_byte_in;

   logic [15:0] tick_sum;
   logic [7:0]  count_sum;
   logic        count_step;

   // Tick arithmetic: counter increment, rate match and timer step.
   assign tick_sum   = tick_counter_ff + 16'd1;
   assign count_sum  = timer_count_ff + 8'd1;
   assign count_step = control_byte_ff[ENABLE_BIT] &&
                       ((tick_sum & rate_mask(control_byte_ff[1:0])) == MATCH_VALUE);

   // Next state and result for the transaction at the input.
   always_comb begin
      tick_counter_in        = tick_counter_ff;
      timer_count_in         = timer_count_ff;
      reload_value_in        = reload_value_ff;
      control_byte_in        = control_byte_ff;
      result.read_data       = 8'd0;
      result.timer_interrupt = 1'b0;
      case (operation)
         OP_TICK: begin
            tick_counter_in = tick_sum;
            if (count_step) begin
               if (count_sum == 8'd0) begin
                  timer_count_in         = reload_value_ff;
                  result.timer_interrupt = 1'b1;
               end else begin
                  timer_count_in = count_sum;
               end
            end
         end
         OP_READ: begin
            unique case (reg_select)
               SEL_DIVIDER: result.read_data = tick_counter_ff[15:8];
               SEL_COUNT:   result.read_data = timer_count_ff;
               SEL_MODULO:  result.read_data = reload_value_ff;
               SEL_CONTROL: result.read_data = control_byte_ff;
               default:     result.read_data = 8'd0;
            endcase
         end
         OP_WRITE: begin
            unique case (reg_select)
               SEL_DIVIDER: tick_counter_in = 16'd0;
               SEL_COUNT:   timer_count_in  = write_data;
               SEL_MODULO:  reload_value_in = write_data;
               SEL_CONTROL: control_byte_in = write_data;
               default:     tick_counter_in = tick_counter_ff;
            endcase
         end
         default: begin
            // Unused operation code leaves all state alone.
         end
      endcase
   end

   // State registers update only on an accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_counter_ff <= 16'd0;
         timer_count_ff  <= 8'd0;
         reload_value_ff <= 8'd0;
         control_byte_ff <= 8'd0;
      end else if (accept) begin
         tick_counter_ff <= tick_counter_in;
         timer_count_ff  <= timer_count_in;
         reload_value_ff <= reload_value_in;
         control_byte_ff <= control_byte_in;
      end
   end

`ifndef ASSERT_OFF
   // An accepted interrupt leaves the timer counter holding the reload value.
   assert property (@(posedge clock) disable iff (reset)
      accept && result.timer_interrupt |=> timer_count_ff == $past(reload_value_ff))
      else $error("timer counter not reloaded after overflow");

   // Without an accepted transaction no architectural register moves.
   assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(tick_counter_ff) && $stable(timer_count_ff) &&
                  $stable(reload_value_ff) && $stable(control_byte_ff))
      else $error("state changed without a transaction");

   // Only a tick can raise the interrupt.
   assert property (@(posedge clock) disable iff (reset)
      operation != OP_TICK |-> !result.timer_interrupt)
      else $error("interrupt raised by a non-tick transaction");
`endif

endmodule

`default_nettype wire

// File: src/dart_out_stage.sv
// ----------------------------------------------------------------------------
// dart_out_stage
// Response register with valid tracking and input ready generation.
// ----------------------------------------------------------------------------
`default_nettype none

module dart_out_stage
   import dart_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire result_type  result,
   output logic             take_ready,
   dart_rsp_if.source       rsp_channel
);

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;

   // A new transaction is taken when the register is empty or drains now.
   assign take_ready   = !out_valid_ff || rsp_channel.ready;
   assign out_valid_in = accept || (out_valid_ff && !rsp_channel.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         out_data_ff <= result;
      end
   end

   assign rsp_channel.valid           = out_valid_ff;
   assign rsp_channel.read_data       = out_data_ff.read_data;
   assign rsp_channel.timer_interrupt = out_data_ff.timer_interrupt;

`ifndef ASSERT_OFF
   // A stalled response blocks new transactions.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_channel.ready |-> !take_ready)
      else $error("input ready while response is stalled");

   // Every accepted transaction produces a pending response.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted transaction lost its response");
`endif

endmodule

`default_nettype wire
